/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file tsc_checker.sv.
// Include guard keeps a second include harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the low-active reset is asserted.
`define ASSERT_RST(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("%m: assertion failed");

// Same, on the block clock clk and reset arst_n.
`define ASSERT_TSC(lbl, prop) `ASSERT_RST(lbl, clk, arst_n, prop)

`endif

/* rtl/core/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Types, constants and the reciprocal table for the Taylor sine/cosine block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

	// field widths
	localparam int ANGLE_W  = 32;
	localparam int VALUE_W  = 32;
	localparam int TERMS_W  = 5;
	localparam int TOL_W    = 29;
	localparam int X2_W     = 34;  // squared angle, at most 16.0 (2^32 at FRAC_BITS = 28)
	localparam int RECIP_W  = 32;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(3);

	// reciprocal table: entry j holds round(2^32 / (j*(j+1))), j = 1..64
	localparam int RECIP_DEPTH = 65;
	localparam int RECIP_IDX_W = 7;

	// multiplier operand sources
	localparam logic [1:0] SRC_SQ = 2'd0;  // |x| * |x|
	localparam logic [1:0] SRC_P  = 2'd1;  // term * x^2
	localparam logic [1:0] SRC_R  = 2'd2;  // partial * reciprocal

	typedef struct packed {
		logic               op;
		logic signed [31:0] angle;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [4:0]         terms_used;
		logic               hit_limit;
	} rsp_word_t;

	typedef struct packed {
		logic       load;
		logic [1:0] src;
		logic       mul_lo;
		logic       mul_hi;
		logic       fin;
		logic       add_term;
		logic       set_hit;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic mag_gt_tol;
		logic cap_full;
	} dp_stat_t;

	typedef logic [RECIP_DEPTH-1:0][RECIP_W-1:0] recip_tab_t;

	// Long division by shift and subtract, evaluated at elaboration only.
	function automatic recip_tab_t build_recip();
		recip_tab_t           tab;
		logic [63:0]          d;
		logic [63:0]          num;
		logic [63:0]          rem;
		logic [RECIP_W-1:0]   q;
		tab = '0;
		for (int j = 1; j < RECIP_DEPTH; j++) begin
			d   = 64'(j) * 64'(j + 1);
			num = (64'd1 << 32) + (d >> 1);
			rem = '0;
			q   = '0;
			for (int b = 33; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= d) begin
					rem = rem - d;
					if (b < RECIP_W) begin
						q[b] = 1'b1;
					end
				end
			end
			tab[j] = q;
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

`default_nettype wire

/* rtl/core/tsc_ctrl.sv */
// ----------------------------------------------------------------------------
// tsc_ctrl
// Sequencer: steps the shared multiplier through the square and each series
// term, and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire tsc_pkg::dp_stat_t stat,
	output tsc_pkg::dp_cmd_t       cmd
);
	import tsc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SQ_LO  = 4'd1;
	localparam logic [3:0] ST_SQ_HI  = 4'd2;
	localparam logic [3:0] ST_SQ_FIN = 4'd3;
	localparam logic [3:0] ST_CHECK  = 4'd4;
	localparam logic [3:0] ST_P_LO   = 4'd5;
	localparam logic [3:0] ST_P_HI   = 4'd6;
	localparam logic [3:0] ST_P_FIN  = 4'd7;
	localparam logic [3:0] ST_R_LO   = 4'd8;
	localparam logic [3:0] ST_R_HI   = 4'd9;
	localparam logic [3:0] ST_R_FIN  = 4'd10;
	localparam logic [3:0] ST_DONE   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.src      = SRC_SQ;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQ_LO;
				end
			end
			ST_SQ_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_SQ_HI;
			end
			ST_SQ_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_SQ_FIN;
			end
			ST_SQ_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!stat.mag_gt_tol) begin
					state_d = ST_DONE;
				end else if (stat.cap_full) begin
					cmd.set_hit = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.add_term = 1'b1;
					state_d      = ST_P_LO;
				end
			end
			ST_P_LO: begin
				cmd.src    = SRC_P;
				cmd.mul_lo = 1'b1;
				state_d    = ST_P_HI;
			end
			ST_P_HI: begin
				cmd.src    = SRC_P;
				cmd.mul_hi = 1'b1;
				state_d    = ST_P_FIN;
			end
			ST_P_FIN: begin
				cmd.src = SRC_P;
				cmd.fin = 1'b1;
				state_d = ST_R_LO;
			end
			ST_R_LO: begin
				cmd.src    = SRC_R;
				cmd.mul_lo = 1'b1;
				state_d    = ST_R_HI;
			end
			ST_R_HI: begin
				cmd.src    = SRC_R;
				cmd.mul_hi = 1'b1;
				state_d    = ST_R_FIN;
			end
			ST_R_FIN: begin
				cmd.src = SRC_R;
				cmd.fin = 1'b1;
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result-valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tsc_dp.sv */
// ----------------------------------------------------------------------------
// tsc_dp
// Datapath: angle clamp, shared split multiplier, term and sum registers,
// tolerance register and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsc_dp #(
	parameter int MAX_TERMS = 16,
	parameter int FRAC_BITS = 28
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [tsc_pkg::TOL_W-1:0]  cfg_wdata,
	input  wire tsc_pkg::req_word_t         req_word,
	input  wire tsc_pkg::dp_cmd_t           cmd,
	output tsc_pkg::dp_stat_t               stat,
	output tsc_pkg::rsp_word_t              rsp_word
);
	import tsc_pkg::*;

	// term magnitudes stay below 16.0, partial products below 256.0
	localparam int MW     = FRAC_BITS + 4;
	localparam int PW     = FRAC_BITS + 8;
	localparam int AH_RAW = (PW + 1) / 2;
	localparam int AH     = (AH_RAW > ANGLE_W / 2) ? AH_RAW : ANGLE_W / 2;
	localparam int AW     = 2 * AH;
	localparam int PRW    = AH + X2_W;
	localparam int ACCW   = AW + X2_W;
	localparam int LW     = (FRAC_BITS + 4 > 34) ? FRAC_BITS + 4 : 34;
	localparam int SW     = (FRAC_BITS + 9 > 33) ? FRAC_BITS + 9 : 33;
	localparam int CW     = (MW > TOL_W) ? MW : TOL_W;
	localparam int UW     = $clog2(MAX_TERMS + 1);
	localparam int TERMS_SAT = (1 << TERMS_W) - 1;

	localparam logic signed [LW-1:0] LIM = LW'(4) << FRAC_BITS;
	localparam logic [MW-1:0]        ONE = MW'(1) << FRAC_BITS;

	logic [TOL_W-1:0]   tol_q;
	logic               op_q;
	logic [ANGLE_W-1:0] xmag_q;
	logic [X2_W-1:0]    x2_q;
	logic [MW-1:0]      mag_q;
	logic               neg_q;
	logic [PW-1:0]      p_q;
	logic [SW-1:0]      sum_q;
	logic [UW-1:0]      used_q;
	logic               hit_q;
	logic [PRW-1:0]     mul_q;
	logic [PRW-1:0]     lo_q;
	rsp_word_t          rsp_q;

	logic signed [LW-1:0]   x_ext;
	logic signed [LW-1:0]   x_clamp;
	logic signed [LW-1:0]   x_abs;
	logic [ANGLE_W-1:0]     xmag;
	logic [RECIP_IDX_W-1:0] ridx;
	logic [RECIP_W-1:0]     recip;
	logic [AW-1:0]          a_op;
	logic [X2_W-1:0]        b_op;
	logic [AH-1:0]          a_part;
	logic [ACCW-1:0]        res;
	logic [VALUE_W-2:0]     unused_chk;
	logic [SW-VALUE_W:0]    sum_top;
	logic signed [VALUE_W-1:0] value_sat;
	logic [TERMS_W-1:0]     terms_sat;

	// clamp to +-4.0 and take the magnitude
	assign x_ext = {{(LW - ANGLE_W){req_word.angle[ANGLE_W-1]}}, req_word.angle};
	always_comb begin
		priority if (x_ext > LIM) begin
			x_clamp = LIM;
		end else if (x_ext < -LIM) begin
			x_clamp = -LIM;
		end else begin
			x_clamp = x_ext;
		end
	end
	assign x_abs = x_clamp[LW-1] ? -x_clamp : x_clamp;
	assign xmag  = x_abs[ANGLE_W-1:0];

	// reciprocal of (k+1)(k+2): index 2*terms - op
	assign ridx  = RECIP_IDX_W'({used_q, 1'b0}) - RECIP_IDX_W'(op_q);
	assign recip = RECIP_TAB[ridx];

	// multiplier operands
	always_comb begin
		unique case (cmd.src)
			SRC_SQ: begin
				a_op = AW'(xmag_q);
				b_op = X2_W'(xmag_q);
			end
			SRC_P: begin
				a_op = AW'(mag_q);
				b_op = x2_q;
			end
			SRC_R: begin
				a_op = AW'(p_q);
				b_op = X2_W'(recip);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end
	assign a_part = cmd.mul_hi ? a_op[AW-1:AH] : a_op[AH-1:0];

	// recombine the two halves
	assign res = ACCW'(lo_q) + (ACCW'(mul_q) << AH);

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// loop control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.load) begin
			used_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.add_term) begin
				used_q <= used_q + UW'(1);
			end
			if (cmd.set_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.mul_lo || cmd.mul_hi) begin
			mul_q <= PRW'(a_part) * PRW'(b_op);
		end
		if (cmd.mul_hi) begin
			lo_q <= mul_q;
		end
		if (cmd.load) begin
			op_q   <= req_word.op;
			xmag_q <= xmag;
			mag_q  <= req_word.op ? ONE : MW'(xmag);
			neg_q  <= req_word.op ? 1'b0 : x_clamp[LW-1];
			sum_q  <= '0;
		end else begin
			if (cmd.add_term) begin
				sum_q <= neg_q ? sum_q - SW'(mag_q) : sum_q + SW'(mag_q);
			end
			if (cmd.fin) begin
				unique case (cmd.src)
					SRC_SQ: x2_q <= X2_W'(res >> FRAC_BITS);
					SRC_P:  p_q  <= PW'(res >> FRAC_BITS);
					SRC_R: begin
						mag_q <= MW'(res >> 32);
						neg_q <= ~neg_q;
					end
					default: ;
				endcase
			end
		end
	end

	// status
	assign stat.mag_gt_tol = CW'(mag_q) > CW'(tol_q);
	assign stat.cap_full   = (used_q == UW'(MAX_TERMS));

	// saturate sum to 32 bits and the term count to the field
	assign sum_top    = sum_q[SW-1:VALUE_W-1];
	assign unused_chk = '0;
	always_comb begin
		if ((&sum_top) || !(|sum_top)) begin
			value_sat = sum_q[VALUE_W-1:0];
		end else if (sum_q[SW-1]) begin
			value_sat = {1'b1, unused_chk};
		end else begin
			value_sat = {1'b0, ~unused_chk};
		end
		if (32'(used_q) > TERMS_SAT) begin
			terms_sat = '1;
		end else begin
			terms_sat = TERMS_W'(used_q);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.value      <= value_sat;
			rsp_q.terms_used <= terms_sat;
			rsp_q.hit_limit  <= hit_q;
		end
	end
	assign rsp_word = rsp_q;

endmodule

`default_nettype wire

/* rtl/core/taylor_sine_cosine_top.sv */
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Sine or cosine of a Q3.28 angle (clamped to +-4.0) by Taylor series, summed
// until a term no longer exceeds the tolerance register or MAX_TERMS terms are
// in. One word is worked at a time; a new word is taken once the previous one
// has moved to the result register. The squared angle is formed first; then each
// term takes two products in series, by x^2 and by the reciprocal, on the single
// split multiplier that does each product as two half-width passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taylor_sine_cosine_top #(
	parameter int MAX_TERMS = 16,
	parameter int FRAC_BITS = 28
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [tsc_pkg::TOL_W-1:0]  cfg_wdata,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire tsc_pkg::req_word_t         req_word,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output tsc_pkg::rsp_word_t              rsp_word
);
	import tsc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	tsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic and storage
	tsc_dp #(
		.MAX_TERMS (MAX_TERMS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_word  (req_word),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_word  (rsp_word)
	);

endmodule

`default_nettype wire

/* rtl/core/tsc_checker.sv */
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks on the Taylor sine/cosine block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tsc_checker #(
	parameter int MAX_TERMS = 16
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire tsc_pkg::rsp_word_t rsp_word
);
	import tsc_pkg::*;

	localparam int CAP = (MAX_TERMS > 31) ? 31 : MAX_TERMS;

	// one word at a time: busy right after a word is taken
	`ASSERT_TSC(a_busy_after_accept, req_valid && req_ready |=> !req_ready)

	// the cap flag only comes with a full count
	`ASSERT_TSC(a_hit_full, rsp_valid && rsp_word.hit_limit |-> rsp_word.terms_used == TERMS_W'(CAP))

	// no terms summed means a zero result
	`ASSERT_TSC(a_empty_zero, rsp_valid && rsp_word.terms_used == '0 |-> rsp_word.value == '0)

	// stalled result holds
	`ASSERT_TSC(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

endmodule

bind taylor_sine_cosine_top tsc_checker #(
	.MAX_TERMS (MAX_TERMS)
) u_tsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_word  (rsp_word)
);

`default_nettype wire
